@@ rtl/script_tokenizer_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Script tokenizer assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef SCRIPT_TOKENIZER_UNIT_ASSERT_SVH
`define SCRIPT_TOKENIZER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property at every clock edge outside reset.
`define STOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define STOK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STOK_ASSERT(lbl, prop, msg)
`define STOK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/stok_pkg.sv @@
// ---------------------------------------------------------------------------
// Script tokenizer package
// Shared types, codes and keyword tables of the script tokenizer.
// ---------------------------------------------------------------------------
package stok_pkg;

  localparam logic [15:0] PosMax    = 16'hFFFF;
  localparam int unsigned WordCount = 9;
  localparam int unsigned QueueDepth = 8;

  // Scan modes; a pending prefix of word w is MODE_PREFIX + w
  localparam logic [3:0] MODE_IDLE   = 4'd0;
  localparam logic [3:0] MODE_NUMBER = 4'd1;
  localparam logic [3:0] MODE_STRING = 4'd2;
  localparam logic [3:0] MODE_NAME   = 4'd3;
  localparam logic [3:0] MODE_PREFIX = 4'd4;

  // Token kinds
  localparam logic [3:0] KIND_INT    = 4'd0;
  localparam logic [3:0] KIND_FLOAT  = 4'd1;
  localparam logic [3:0] KIND_STRING = 4'd2;
  localparam logic [3:0] KIND_NAME   = 4'd3;
  localparam logic [3:0] KIND_BOOL   = 4'd4;
  localparam logic [3:0] KIND_KEYWORD = 4'd5;
  localparam logic [3:0] KIND_OP     = 4'd6;
  localparam logic [3:0] KIND_PUNCT  = 4'd7;
  localparam logic [3:0] KIND_END    = 4'd8;
  localparam logic [3:0] KIND_ERROR  = 4'd9;

  localparam logic [3:0] ERR_SYMBOL  = 4'd0;
  localparam logic [3:0] ERR_QUOTE   = 4'd1;
  localparam logic [3:0] PUNCT_DOT   = 4'd0;
  localparam logic [3:0] WORD_EQ     = 4'd6;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_QUOTE = 8'h27;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  localparam logic [7:0] PunctChars [5] = '{".", ",", "|", "(", ")"};
  localparam logic [7:0] OpChars    [6] = '{"+", "-", "/", "*", "^", "%"};

  localparam logic [7:0] WordText [16][8] = '{
    0: '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    1: '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
    2: '{"d", "e", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    3: '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    4: '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    5: '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    6: '{"=", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    7: '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    8: '{"a", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    default: '{default: 8'h00}
  };
  localparam logic [3:0] WordLen [16] = '{0: 4'd4, 1: 4'd5, 2: 4'd3, 3: 4'd2, 4: 4'd4,
    5: 4'd3, 6: 4'd2, 7: 4'd2, 8: 4'd3, default: 4'd0};
  localparam logic [3:0] WordKind [16] = '{0: KIND_BOOL, 1: KIND_BOOL, 2: KIND_KEYWORD,
    3: KIND_KEYWORD, 4: KIND_KEYWORD, 5: KIND_KEYWORD, 6: KIND_OP, 7: KIND_OP,
    8: KIND_OP, default: 4'd0};
  localparam logic [3:0] WordVar [16] = '{0: 4'd1, 1: 4'd0, 2: 4'd0, 3: 4'd1, 4: 4'd2,
    5: 4'd3, 6: 4'd6, 7: 4'd7, 8: 4'd8, default: 4'd0};

  typedef struct packed {
    logic [3:0]  mode;
    logic [3:0]  prog;
    logic        is_int;
    logic        dot;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] tsc;
    logic [15:0] run;
    logic        halted;
  } scan_state_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  variant;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } token_t;

  typedef struct packed {
    token_t [3:0] tok;
    logic [2:0]   count;
  } result_set_t;

  function automatic scan_state_t reset_state();
    scan_state_t s;
    s        = '0;
    s.mode   = MODE_IDLE;
    s.is_int = 1'b1;
    s.line   = 16'd1;
    s.col    = 16'd1;
    return s;
  endfunction

endpackage

@@ rtl/stok_if.sv @@
// ---------------------------------------------------------------------------
// Script tokenizer channels
// Valid/ready channels for characters in and token descriptors out.
// ---------------------------------------------------------------------------
interface stok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_script;
  modport source (output valid, char_code, end_of_script, input ready);
  modport sink   (input valid, char_code, end_of_script, output ready);
endinterface

interface stok_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [3:0]  token_variant;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] token_length;
  logic        last_of_run;
  modport source (output valid, token_kind, token_variant, start_line, start_column,
                  token_length, last_of_run, input ready);
  modport sink   (input valid, token_kind, token_variant, start_line, start_column,
                  token_length, last_of_run, output ready);
endinterface

@@ rtl/stok_step.sv @@
// ---------------------------------------------------------------------------
// Script tokenizer step logic
// Next scan state and up to four token descriptors for one character.
// ---------------------------------------------------------------------------
module stok_step (
  input  stok_pkg::scan_state_t state_i,
  input  logic [7:0]            char_i,
  input  logic                  last_i,
  output stok_pkg::scan_state_t state_o,
  output stok_pkg::result_set_t res_o
);
  import stok_pkg::*;

  typedef struct packed {
    scan_state_t s;
    result_set_t r;
  } step_t;

  function automatic logic [15:0] sat_inc(logic [15:0] x);
    return (x == PosMax) ? x : x + 16'd1;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_name(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic token_t mk_tok(logic [3:0] kind, logic [3:0] variant,
                                    logic [15:0] line, logic [15:0] col,
                                    logic [15:0] len);
    token_t t;
    t.kind = kind;
    t.variant = variant;
    t.line = line;
    t.col = col;
    t.len = len;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic result_set_t push(result_set_t r, token_t t);
    result_set_t o;
    o = r;
    if (r.count < 3'd4) begin
      o.tok[r.count[1:0]] = t;
      o.count = r.count + 3'd1;
    end
    return o;
  endfunction

  // Handle a character with no token in progress
  function automatic step_t fresh(step_t x, logic [7:0] c);
    step_t       y;
    logic        p_hit, o_hit, w_hit;
    logic [3:0]  p_idx, o_idx, w_idx;
    scan_state_t s;
    y = x;
    s = x.s;
    y.s.mode = MODE_IDLE;
    p_hit = 1'b0; o_hit = 1'b0; w_hit = 1'b0;
    p_idx = '0; o_idx = '0; w_idx = '0;
    for (int i = 4; i >= 0; i--) begin
      if (PunctChars[i] == c) begin
        p_hit = 1'b1;
        p_idx = 4'(i);
      end
    end
    for (int i = 5; i >= 0; i--) begin
      if (OpChars[i] == c) begin
        o_hit = 1'b1;
        o_idx = 4'(i);
      end
    end
    for (int i = WordCount - 1; i >= 0; i--) begin
      if (WordText[i][0] == c) begin
        w_hit = 1'b1;
        w_idx = 4'(i);
      end
    end
    if (c == CHAR_SPACE) begin
      y.s.col = sat_inc(s.col);
    end else if (c == CHAR_LF || c == CHAR_CR) begin
      y.s.line = sat_inc(s.line);
      y.s.col = 16'd1;
    end else if (p_hit) begin
      y.r = push(y.r, mk_tok(KIND_PUNCT, p_idx, s.line, s.col, 16'd1));
      y.s.col = sat_inc(s.col);
    end else if (is_digit(c)) begin
      y.s.mode = MODE_NUMBER;
      y.s.tsc = s.col;
      y.s.run = 16'd1;
      y.s.is_int = 1'b1;
      y.s.dot = 1'b0;
      y.s.col = sat_inc(s.col);
    end else if (c == CHAR_QUOTE) begin
      y.s.mode = MODE_STRING;
      y.s.tsc = sat_inc(s.col);
      y.s.run = '0;
      y.s.col = sat_inc(s.col);
    end else if (w_hit) begin
      y.s.mode = MODE_PREFIX + w_idx;
      y.s.prog = 4'd1;
      y.s.tsc = s.col;
      y.s.col = sat_inc(s.col);
    end else if (o_hit) begin
      y.r = push(y.r, mk_tok(KIND_OP, o_idx, s.line, s.col, 16'd1));
      y.s.col = sat_inc(s.col);
    end else if (is_name(c)) begin
      y.s.mode = MODE_NAME;
      y.s.tsc = s.col;
      y.s.run = 16'd1;
      y.s.col = sat_inc(s.col);
    end else begin
      y.r = push(y.r, mk_tok(KIND_ERROR, ERR_SYMBOL, s.line, s.col, 16'd1));
      y.s.halted = 1'b1;
    end
    return y;
  endfunction

  function automatic logic [15:0] dot_col(logic [15:0] col);
    return (col == PosMax || col == '0) ? col : col - 16'd1;
  endfunction

  function automatic step_t step_char(scan_state_t s, logic [7:0] c);
    step_t      y;
    logic [3:0] w, p, v_idx;
    logic       found, m;
    y.s = s;
    y.r = '0;
    w = s.mode - MODE_PREFIX;
    p = s.prog;
    found = 1'b0;
    v_idx = '0;
    case (s.mode)
      MODE_IDLE: begin
        y = fresh(y, c);
      end
      MODE_NUMBER: begin
        if (s.dot) begin
          y.s.dot = 1'b0;
          if (is_digit(c)) begin
            y.s.is_int = 1'b0;
            y.s.run = sat_inc(sat_inc(s.run));
            y.s.col = sat_inc(s.col);
          end else begin
            y.r = push(y.r, mk_tok(KIND_INT, 4'd0, s.line, s.tsc, s.run));
            y.r = push(y.r, mk_tok(KIND_PUNCT, PUNCT_DOT, s.line, dot_col(s.col), 16'd1));
            y = fresh(y, c);
          end
        end else if (is_digit(c)) begin
          y.s.run = sat_inc(s.run);
          y.s.col = sat_inc(s.col);
        end else if (c == CHAR_DOT && s.is_int) begin
          y.s.dot = 1'b1;
          y.s.col = sat_inc(s.col);
        end else begin
          y.r = push(y.r, mk_tok(s.is_int ? KIND_INT : KIND_FLOAT, 4'd0, s.line, s.tsc,
                                 s.run));
          y = fresh(y, c);
        end
      end
      MODE_STRING: begin
        if (c == CHAR_QUOTE) begin
          y.r = push(y.r, mk_tok(KIND_STRING, 4'd0, s.line, s.tsc, s.run));
          y.s.mode = MODE_IDLE;
        end else begin
          y.s.run = sat_inc(s.run);
        end
        y.s.col = sat_inc(s.col);
      end
      MODE_NAME: begin
        if (is_name(c)) begin
          y.s.run = sat_inc(s.run);
          y.s.col = sat_inc(s.col);
        end else begin
          y.r = push(y.r, mk_tok(KIND_NAME, 4'd0, s.line, s.tsc, s.run));
          y = fresh(y, c);
        end
      end
      default: begin
        if (w >= 4'(WordCount) || p == '0 || p >= WordLen[w]) begin
          y = fresh(y, c);
        end else begin
          // Look for a word that shares the prefix so far and continues with c
          for (int v = WordCount - 1; v >= 0; v--) begin
            m = WordLen[v] > p;
            for (int k = 0; k < 5; k++) begin
              if (4'(k) < p && WordText[v][k] != WordText[w][k]) m = 1'b0;
            end
            if (m && WordText[v][p[2:0]] == c) begin
              found = 1'b1;
              v_idx = 4'(v);
            end
          end
          if (found) begin
            if (p + 4'd1 == WordLen[v_idx]) begin
              y.r = push(y.r, mk_tok(WordKind[v_idx], WordVar[v_idx], s.line, s.tsc,
                                     16'(WordLen[v_idx])));
              y.s.mode = MODE_IDLE;
            end else begin
              y.s.mode = MODE_PREFIX + v_idx;
              y.s.prog = p + 4'd1;
            end
            y.s.col = sat_inc(s.col);
          end else if (w == WORD_EQ) begin
            y.r = push(y.r, mk_tok(KIND_ERROR, ERR_SYMBOL, s.line, s.tsc, 16'd1));
            y.s.halted = 1'b1;
          end else if (is_name(c)) begin
            y.s.mode = MODE_NAME;
            y.s.run = 16'(p) + 16'd1;
            y.s.col = sat_inc(s.col);
          end else begin
            y.r = push(y.r, mk_tok(KIND_NAME, 4'd0, s.line, s.tsc, 16'(p)));
            y = fresh(y, c);
          end
        end
      end
    endcase
    return y;
  endfunction

  // Close the pending token at end of script and append the end marker unless halted
  function automatic step_t flush(step_t x);
    step_t       y;
    scan_state_t s;
    logic [3:0]  w;
    y = x;
    s = x.s;
    w = s.mode - MODE_PREFIX;
    case (s.mode)
      MODE_IDLE: begin
      end
      MODE_NUMBER: begin
        y.r = push(y.r, mk_tok(s.is_int ? KIND_INT : KIND_FLOAT, 4'd0, s.line, s.tsc,
                               s.run));
        if (s.dot) begin
          y.r = push(y.r, mk_tok(KIND_PUNCT, PUNCT_DOT, s.line, dot_col(s.col), 16'd1));
        end
      end
      MODE_STRING: begin
        y.r = push(y.r, mk_tok(KIND_ERROR, ERR_QUOTE, s.line, s.col, 16'd0));
        y.s.halted = 1'b1;
      end
      MODE_NAME: begin
        y.r = push(y.r, mk_tok(KIND_NAME, 4'd0, s.line, s.tsc, s.run));
      end
      default: begin
        if (w == WORD_EQ) begin
          y.r = push(y.r, mk_tok(KIND_ERROR, ERR_SYMBOL, s.line, s.tsc, 16'd1));
          y.s.halted = 1'b1;
        end else begin
          y.r = push(y.r, mk_tok(KIND_NAME, 4'd0, s.line, s.tsc, 16'(s.prog)));
        end
      end
    endcase
    if (!y.s.halted) begin
      y.r = push(y.r, mk_tok(KIND_END, 4'd0, 16'd0, 16'd0, 16'd0));
    end
    return y;
  endfunction

  always_comb begin
    step_t x;
    x = step_char(state_i, char_i);
    if (last_i && !x.s.halted) x = flush(x);
    if (state_i.halted) begin
      x.s = state_i;
      x.r = '0;
    end
    if (last_i) x.s = reset_state();
    if (x.r.count != '0) x.r.tok[2'(x.r.count - 3'd1)].last = 1'b1;
    state_o = x.s;
    res_o = x.r;
  end

endmodule

@@ rtl/stok_rqueue.sv @@
// ---------------------------------------------------------------------------
// Script tokenizer result queue
// Eight-entry token queue: takes up to four tokens per cycle, gives one.
// ---------------------------------------------------------------------------
module stok_rqueue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stok_pkg::result_set_t push_i,
  input  logic                  pop_i,
  output logic                  room_o,
  output logic                  valid_o,
  output stok_pkg::token_t      head_o,
  output logic [3:0]            count_o
);
  import stok_pkg::*;

  token_t     mem_q [QueueDepth];
  logic [2:0] wp_q, wp_d, rp_q, rp_d;
  logic [3:0] cnt_q, cnt_d;

  assign valid_o = cnt_q != '0;
  assign room_o  = cnt_q <= 4'(QueueDepth - 4);
  assign head_o  = mem_q[rp_q];
  assign count_o = cnt_q;

  always_comb begin
    wp_d  = wp_q + push_i.count;
    rp_d  = rp_q + 3'(pop_i);
    cnt_d = cnt_q + 4'(push_i.count) - 4'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < push_i.count) mem_q[wp_q + 3'(k)] <= push_i.tok[k];
    end
  end

endmodule

@@ rtl/script_tokenizer_unit.sv @@
// ---------------------------------------------------------------------------
// Script tokenizer unit
// Turns a stream of script characters into token descriptors.
// ---------------------------------------------------------------------------
// One character is taken per cycle while the result queue has room. A
// transferred character sits in an input register, where the step logic
// works out the new scan state and the zero to four tokens it causes; those
// enter an eight-entry result queue that drains one token per cycle while
// the sink is ready. A character's first token passes through the input
// register and the result queue to the output. The input side stalls only
// while the queue has fewer than four free entries, so a sustained rate of
// one character per cycle holds as long as characters average no more than
// one token each and the sink keeps up; the queue drain limits it otherwise.
`include "script_tokenizer_unit_assert.svh"

module script_tokenizer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  stok_char_if.sink    char_i,
  stok_token_if.source token_o
);
  import stok_pkg::*;

  scan_state_t state_q, state_d;
  result_set_t res;
  token_t      head;
  logic        inv_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic        fire, room, pop, qvalid;
  logic [3:0]  qcount;
  logic [2:0]  push_n;

  // Advance the held character once the queue has room for its tokens
  assign fire         = inv_q && room;
  assign char_i.ready = !inv_q || fire;
  assign pop          = qvalid && token_o.ready;
  assign push_n       = fire ? res.count : 3'd0;

  stok_step u_step (
    .state_i (state_q),
    .char_i  (char_q),
    .last_i  (last_q),
    .state_o (state_d),
    .res_o   (res)
  );

  result_set_t push_set;
  always_comb begin
    push_set       = res;
    push_set.count = push_n;
  end

  stok_rqueue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_set),
    .pop_i   (pop),
    .room_o  (room),
    .valid_o (qvalid),
    .head_o  (head),
    .count_o (qcount)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q   <= 1'b0;
      state_q <= reset_state();
    end else begin
      if (char_i.ready) inv_q <= char_i.valid;
      if (fire) state_q <= state_d;
    end
  end

  // Payload of the input register: load on every transfer
  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      char_q <= char_i.char_code;
      last_q <= char_i.end_of_script;
    end
  end

  assign token_o.valid         = qvalid;
  assign token_o.token_kind    = head.kind;
  assign token_o.token_variant = head.variant;
  assign token_o.start_line    = head.line;
  assign token_o.start_column  = head.col;
  assign token_o.token_length  = head.len;
  assign token_o.last_of_run   = head.last;

  // Queue never overfills
  `STOK_ASSERT(a_queue_bound, qcount <= 4'(QueueDepth), "result queue overflow")
  // Occupancy follows pushes and pops
  `STOK_ASSERT_NEXT(a_queue_track, 1'b1, qcount == 4'($past(qcount) + 4'($past(push_n)) - 4'($past(pop))), "result queue count mismatch")
  // The final character of a script leaves the scanner clear
  `STOK_ASSERT_NEXT(a_script_end, fire && last_q, state_q.mode == MODE_IDLE && !state_q.halted, "scanner not cleared after end of script")

endmodule
